// ===== hdl/ffa_pkg.sv =====
// Shared constants, codes and state type for the first-fit capacity allocator.
package ffa_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 1024;
  localparam int unsigned CAP_WIDTH_DEF = 32;
  localparam int unsigned HOTEL_COUNT_RST = 1024;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DOWN,
    ST_UP,
    ST_DONE
  } ffa_state_e;

endpackage

// ===== hdl/ffa_tree_mem.sv =====
// Tree store: one row per parent node holding its two children, registered read.
module ffa_tree_mem #(
  parameter int unsigned ROW_AW = 10,
  parameter int unsigned DW     = 64
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ROW_AW-1:0] waddr_i,
  input  logic [DW-1:0]     wdata_i,
  input  logic [ROW_AW-1:0] raddr_i,
  output logic [DW-1:0]     rdata_o
);

  logic [DW-1:0] mem [2**ROW_AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ffa_seq.sv =====
// Walk sequencer: clearing sweep, descent over the tree rows, path rewrite on the way up.
module ffa_seq #(
  parameter int unsigned MAX_SLOTS = ffa_pkg::MAX_SLOTS_DEF,
  parameter int unsigned CAP_WIDTH = ffa_pkg::CAP_WIDTH_DEF,
  localparam int unsigned IDX_W = $clog2(MAX_SLOTS),
  localparam int unsigned CNT_W = IDX_W + 1,
  localparam int unsigned ROW_W = 2 * CAP_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic [IDX_W-1:0]     slot_index_i,
  input  logic [CAP_WIDTH-1:0] amount_i,
  input  logic [CNT_W-1:0]     count_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic [CNT_W-1:0]     res_slot_o,
  output logic                 mem_we_o,
  output logic [IDX_W-1:0]     mem_waddr_o,
  output logic [ROW_W-1:0]     mem_wdata_o,
  output logic [IDX_W-1:0]     mem_raddr_o,
  input  logic [ROW_W-1:0]     mem_rdata_i
);

  localparam int unsigned LVL_W = (IDX_W > 1) ? $clog2(IDX_W) : 1;

  ffa_pkg::ffa_state_e state_q, state_d;
  logic [IDX_W-1:0]     clr_q, clr_d;
  logic                 func_q, func_d;
  logic [IDX_W-1:0]     slot_q, slot_d;
  logic [CAP_WIDTH-1:0] amt_q, amt_d;
  logic [IDX_W-1:0]     node_q, node_d;
  logic [IDX_W-1:0]     pos_q, pos_d;
  logic [IDX_W-1:0]     bit_q, bit_d;
  logic [LVL_W-1:0]     lvl_q, lvl_d;
  logic [CAP_WIDTH-1:0] val_q, val_d;
  logic                 hit_q, hit_d;
  logic [CAP_WIDTH-1:0] sib_q [2**LVL_W];

  logic [CAP_WIDTH-1:0] rd_lo, rd_hi, chosen, sib_rd;
  logic                 left_in, left_part, go_left, dir_dn, dir_up, sib_we, leaf_hit;
  logic [IDX_W-1:0]     pos_new;

  assign rd_lo  = mem_rdata_i[CAP_WIDTH-1:0];
  assign rd_hi  = mem_rdata_i[ROW_W-1:CAP_WIDTH];
  assign sib_rd = sib_q[lvl_q];
  assign dir_up = |(pos_q & bit_q);

  // left child fully below the count, or straddling it (then the right one is out)
  assign left_in   = {1'b0, pos_q | bit_q} <= count_i;
  assign left_part = ({1'b0, pos_q} < count_i) && !left_in;
  assign go_left   = (left_in && (rd_lo >= amt_q)) || left_part;
  assign dir_dn    = (func_q == ffa_pkg::FUNC_REQUEST) ? !go_left : |(slot_q & bit_q);
  assign chosen    = dir_dn ? rd_hi : rd_lo;
  assign pos_new   = pos_q | (dir_dn ? bit_q : '0);
  assign leaf_hit  = (func_q == ffa_pkg::FUNC_REQUEST)
                   ? (({1'b0, pos_new} < count_i) && (chosen >= amt_q))
                   : ({1'b0, slot_q} < count_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffa_pkg::ST_CLEAR;
      clr_q   <= '0;
      func_q  <= ffa_pkg::FUNC_LOAD;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      func_q  <= func_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    amt_q  <= amt_d;
    node_q <= node_d;
    pos_q  <= pos_d;
    bit_q  <= bit_d;
    lvl_q  <= lvl_d;
    val_q  <= val_d;
    if (sib_we) begin
      sib_q[lvl_q] <= dir_dn ? rd_lo : rd_hi;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    func_d      = func_q;
    slot_d      = slot_q;
    amt_d       = amt_q;
    node_d      = node_q;
    pos_d       = pos_q;
    bit_d       = bit_q;
    lvl_d       = lvl_q;
    val_d       = val_q;
    hit_d       = hit_q;
    sib_we      = 1'b0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = node_q;
    mem_wdata_o = dir_up ? {val_q, sib_rd} : {sib_rd, val_q};
    mem_raddr_o = node_q;
    case (state_q)
      ffa_pkg::ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '0;
        clr_d       = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = ffa_pkg::ST_IDLE;
        end
      end
      ffa_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        mem_raddr_o = IDX_W'(1);
        if (in_valid_i) begin
          func_d  = func_i;
          slot_d  = slot_index_i;
          amt_d   = amount_i;
          node_d  = IDX_W'(1);
          pos_d   = '0;
          bit_d   = IDX_W'(1) << (IDX_W - 1);
          lvl_d   = '0;
          state_d = ffa_pkg::ST_DOWN;
        end
      end
      ffa_pkg::ST_DOWN: begin
        sib_we = 1'b1;
        pos_d  = pos_new;
        if (bit_q[0]) begin
          hit_d = leaf_hit;
          val_d = (func_q == ffa_pkg::FUNC_REQUEST) ? chosen - amt_q : amt_q;
          if (leaf_hit) begin
            state_d = ffa_pkg::ST_UP;
          end else if (func_q == ffa_pkg::FUNC_REQUEST) begin
            state_d = ffa_pkg::ST_DONE;
          end else begin
            state_d = ffa_pkg::ST_IDLE;
          end
        end else begin
          node_d      = IDX_W'({node_q, dir_dn});
          mem_raddr_o = node_d;
          bit_d       = bit_q >> 1;
          lvl_d       = lvl_q + 1'b1;
        end
      end
      ffa_pkg::ST_UP: begin
        mem_we_o = 1'b1;
        val_d    = (sib_rd > val_q) ? sib_rd : val_q;
        node_d   = node_q >> 1;
        bit_d    = bit_q << 1;
        lvl_d    = lvl_q - 1'b1;
        if (lvl_q == '0) begin
          state_d = (func_q == ffa_pkg::FUNC_REQUEST) ? ffa_pkg::ST_DONE : ffa_pkg::ST_IDLE;
        end
      end
      ffa_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ffa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ffa_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_slot_o = hit_q ? ({1'b0, pos_q} + CNT_W'(1)) : '0;

endmodule

// ===== hdl/first_fit_capacity_allocator.sv =====
// Top level of the first-fit capacity allocator: count register, result register, tree store.
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+-----------------------------------
//  input     | in        | in_valid_i / in_stall_o   | func_i, slot_index_i, amount_i
//  result    | out       | out_valid_o / out_stall_i | chosen_slot_o
//  count cfg | in        | hotel_count_we_i          | hotel_count_i
//
// Each transaction reads one row per tree level going down and writes one row per level going up,
// through the store's one read port and one write port.
// A load outside the count or a request that finds no slot skips the rewrite.
// After reset the store is swept clear, one row per cycle, with in_stall_o high.
// The result register frees the walk while a result waits on out_stall_i.
module first_fit_capacity_allocator #(
  parameter int unsigned MAX_SLOTS = ffa_pkg::MAX_SLOTS_DEF,
  parameter int unsigned CAP_WIDTH = ffa_pkg::CAP_WIDTH_DEF,
  localparam int unsigned IDX_W = $clog2(MAX_SLOTS),
  localparam int unsigned CNT_W = IDX_W + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  logic [IDX_W-1:0]     slot_index_i,
  input  logic [CAP_WIDTH-1:0] amount_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CNT_W-1:0]     chosen_slot_o,
  input  logic                 hotel_count_we_i,
  input  logic [CNT_W-1:0]     hotel_count_i
);

  localparam int unsigned CNT_RST = (MAX_SLOTS < ffa_pkg::HOTEL_COUNT_RST)
                                  ? MAX_SLOTS : ffa_pkg::HOTEL_COUNT_RST;
  localparam int unsigned ROW_W = 2 * CAP_WIDTH;

  logic [CNT_W-1:0] hotel_count_q;
  logic [CNT_W-1:0] count_eff;
  logic             in_ready, res_valid, res_ready;
  logic [CNT_W-1:0] res_slot;
  logic             out_valid_q;
  logic [CNT_W-1:0] out_slot_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [ROW_W-1:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hotel_count_q <= CNT_W'(CNT_RST);
    end else if (hotel_count_we_i) begin
      hotel_count_q <= hotel_count_i;
    end
  end

  assign count_eff = (hotel_count_q > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : hotel_count_q;

  ffa_seq #(
    .MAX_SLOTS(MAX_SLOTS),
    .CAP_WIDTH(CAP_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .func_i      (func_i),
    .slot_index_i(slot_index_i),
    .amount_i    (amount_i),
    .count_i     (count_eff),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_slot_o  (res_slot),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ffa_tree_mem #(
    .ROW_AW(IDX_W),
    .DW    (ROW_W)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_slot_q <= res_slot;
    end
  end

  assign in_stall_o    = !in_ready;
  assign out_valid_o   = out_valid_q;
  assign chosen_slot_o = out_slot_q;

  a_slot_in_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (chosen_slot_o <= count_eff))
    else $error("chosen slot beyond slots in use");

  a_no_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> !mem_we)
    else $error("store written while idle");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("transaction accepted while walk in progress");

  a_result_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> (out_valid_o && in_stall_o == 1'b0))
    else $error("result not registered");

endmodule
